### rtl/rdtv_pkg.sv
`default_nettype none

package rdtv_pkg;

  // Parser steps
  typedef enum logic [2:0] {
    PH_DATE      = 3'd0,
    PH_SEP       = 3'd1,
    PH_TIME      = 3'd2,
    PH_AFTER_SEC = 3'd3,
    PH_FRAC_1ST  = 3'd4,
    PH_FRAC      = 3'd5,
    PH_ZONE      = 3'd6,
    PH_END       = 3'd7
  } phase_e;

  // Format selection codes
  localparam logic [1:0] FMT_DATE      = 2'd0;
  localparam logic [1:0] FMT_TIME      = 2'd1;
  localparam logic [1:0] FMT_DATE_TIME = 2'd2;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_UP_T  = 8'h54;
  localparam logic [7:0] CH_LO_T  = 8'h74;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CH_LO_Z  = 8'h7a;

  // Field limits
  localparam logic [6:0] HOUR_MAX  = 7'd23;
  localparam logic [6:0] MIN_MAX   = 7'd59;
  localparam logic [6:0] SEC_MAX   = 7'd60;
  localparam logic [6:0] MONTH_MAX = 7'd12;

  // Positions inside the date, time and zone steps
  localparam logic [3:0] DPOS_CENT_END = 4'd2;
  localparam logic [3:0] DPOS_DASH1    = 4'd4;
  localparam logic [3:0] DPOS_DASH2    = 4'd7;
  localparam logic [3:0] DPOS_LAST     = 4'd9;
  localparam logic [3:0] TPOS_HOUR     = 4'd1;
  localparam logic [3:0] TPOS_COLON1   = 4'd2;
  localparam logic [3:0] TPOS_MIN      = 4'd4;
  localparam logic [3:0] TPOS_COLON2   = 4'd5;
  localparam logic [3:0] TPOS_SEC      = 4'd7;
  localparam logic [3:0] ZPOS_FIRST    = 4'd1;
  localparam logic [3:0] ZPOS_HOUR     = 4'd2;
  localparam logic [3:0] ZPOS_COLON    = 4'd3;
  localparam logic [3:0] ZPOS_MIN      = 4'd5;

  localparam logic [1:0] FMT_RESET = FMT_DATE_TIME;

  // Parser state; the year is held as century and year-in-century
  typedef struct packed {
    phase_e     phase;
    logic [3:0] pos;
    logic [6:0] cent;
    logic [6:0] yic;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] field;
    logic       failed;
  } state_t;

  // State at the start of a string
  function automatic state_t start_state(input logic [1:0] fmt);
    state_t s;
    s        = '0;
    s.phase  = (fmt == FMT_TIME) ? PH_TIME : PH_DATE;
    return s;
  endfunction

  // Days in a month (1..12), February by the leap flag
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    n = 5'd30;
      4'd2:                                       n = leap ? 5'd29 : 5'd28;
      default:                                    n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/rdtv_step.sv
`default_nettype none

module rdtv_step (
  input  rdtv_pkg::state_t state_i,
  input  logic [1:0]       format_kind_i,
  input  logic [7:0]       text_char_i,
  output rdtv_pkg::state_t state_o
);

  logic             is_dig;
  logic [3:0]       digit;
  logic [6:0]       acc_base;
  logic [9:0]       acc_wide;
  logic [6:0]       acc;
  logic             is_z;
  logic             is_sign;
  logic             leap;
  logic [4:0]       mlen;
  logic             month_ok;
  rdtv_pkg::phase_e phase_d;
  rdtv_pkg::state_t data_d;

  // Character classes
  assign is_dig  = (text_char_i >= rdtv_pkg::CH_ZERO) && (text_char_i <= rdtv_pkg::CH_NINE);
  assign digit   = text_char_i[3:0];
  assign is_z    = (text_char_i == rdtv_pkg::CH_UP_Z) || (text_char_i == rdtv_pkg::CH_LO_Z);
  assign is_sign = (text_char_i == rdtv_pkg::CH_PLUS) || (text_char_i == rdtv_pkg::CH_DASH);

  // Decimal accumulator, shared by every two-digit field
  always_comb begin
    if (state_i.phase == rdtv_pkg::PH_DATE) begin
      if (state_i.pos < rdtv_pkg::DPOS_CENT_END)   acc_base = state_i.cent;
      else if (state_i.pos < rdtv_pkg::DPOS_DASH1) acc_base = state_i.yic;
      else if (state_i.pos < rdtv_pkg::DPOS_DASH2) acc_base = state_i.month;
      else                                         acc_base = state_i.day;
    end else begin
      acc_base = state_i.field;
    end
  end

  assign acc_wide = {acc_base, 3'b000} + {2'b00, acc_base, 1'b0} + {6'd0, digit};
  assign acc      = acc_wide[6:0];

  // Leap year from century and year-in-century, no division
  assign leap     = (state_i.yic == 7'd0) ? (state_i.cent[1:0] == 2'b00)
                                          : (state_i.yic[1:0] == 2'b00);
  assign month_ok = (state_i.month != 7'd0) && (state_i.month <= rdtv_pkg::MONTH_MAX);
  assign mlen     = rdtv_pkg::month_len(state_i.month[3:0], leap);

  // Next parser step; a mismatch is caught by the failed flag instead
  always_comb begin
    phase_d = state_i.phase;
    unique case (state_i.phase)
      rdtv_pkg::PH_DATE: begin
        if (state_i.pos == rdtv_pkg::DPOS_LAST) begin
          phase_d = (format_kind_i == rdtv_pkg::FMT_DATE) ? rdtv_pkg::PH_END
                                                          : rdtv_pkg::PH_SEP;
        end
      end
      rdtv_pkg::PH_SEP: phase_d = rdtv_pkg::PH_TIME;
      rdtv_pkg::PH_TIME: begin
        if (state_i.pos == rdtv_pkg::TPOS_SEC) phase_d = rdtv_pkg::PH_AFTER_SEC;
      end
      rdtv_pkg::PH_AFTER_SEC: begin
        if (text_char_i == rdtv_pkg::CH_DOT) phase_d = rdtv_pkg::PH_FRAC_1ST;
        else if (is_z)                        phase_d = rdtv_pkg::PH_END;
        else if (is_sign)                     phase_d = rdtv_pkg::PH_ZONE;
      end
      rdtv_pkg::PH_FRAC_1ST: phase_d = rdtv_pkg::PH_FRAC;
      rdtv_pkg::PH_FRAC: begin
        if (is_z)         phase_d = rdtv_pkg::PH_END;
        else if (is_sign) phase_d = rdtv_pkg::PH_ZONE;
      end
      rdtv_pkg::PH_ZONE: begin
        if (state_i.pos == rdtv_pkg::ZPOS_MIN) phase_d = rdtv_pkg::PH_END;
      end
      rdtv_pkg::PH_END: phase_d = rdtv_pkg::PH_END;
      default: phase_d = state_i.phase;
    endcase
  end

  // Fields, position and mismatch flag
  always_comb begin
    data_d = state_i;
    unique case (state_i.phase)
      rdtv_pkg::PH_DATE: begin
        if ((state_i.pos == rdtv_pkg::DPOS_DASH1) || (state_i.pos == rdtv_pkg::DPOS_DASH2)) begin
          data_d.failed = (text_char_i != rdtv_pkg::CH_DASH);
        end else begin
          data_d.failed = !is_dig;
          if (state_i.pos < rdtv_pkg::DPOS_CENT_END)   data_d.cent  = acc;
          else if (state_i.pos < rdtv_pkg::DPOS_DASH1) data_d.yic   = acc;
          else if (state_i.pos < rdtv_pkg::DPOS_DASH2) data_d.month = acc;
          else                                         data_d.day   = acc;
        end
        if (state_i.pos == rdtv_pkg::DPOS_LAST) begin
          if (!month_ok || (acc == 7'd0) || (acc > {2'b00, mlen})) data_d.failed = 1'b1;
          data_d.pos = 4'd0;
        end else begin
          data_d.pos = 4'(state_i.pos + 4'd1);
        end
      end
      rdtv_pkg::PH_SEP: begin
        data_d.failed = !((text_char_i == rdtv_pkg::CH_UP_T) ||
                          (text_char_i == rdtv_pkg::CH_LO_T));
        data_d.pos    = 4'd0;
        data_d.field  = 7'd0;
      end
      rdtv_pkg::PH_TIME: begin
        if ((state_i.pos == rdtv_pkg::TPOS_COLON1) || (state_i.pos == rdtv_pkg::TPOS_COLON2)) begin
          data_d.failed = (text_char_i != rdtv_pkg::CH_COLON);
          data_d.field  = 7'd0;
          data_d.pos    = 4'(state_i.pos + 4'd1);
        end else begin
          data_d.failed = !is_dig ||
                          ((state_i.pos == rdtv_pkg::TPOS_HOUR) && (acc > rdtv_pkg::HOUR_MAX)) ||
                          ((state_i.pos == rdtv_pkg::TPOS_MIN)  && (acc > rdtv_pkg::MIN_MAX))  ||
                          ((state_i.pos == rdtv_pkg::TPOS_SEC)  && (acc > rdtv_pkg::SEC_MAX));
          if (state_i.pos == rdtv_pkg::TPOS_SEC) begin
            data_d.field = 7'd0;
            data_d.pos   = 4'd0;
          end else begin
            data_d.field = acc;
            data_d.pos   = 4'(state_i.pos + 4'd1);
          end
        end
      end
      rdtv_pkg::PH_AFTER_SEC: begin
        data_d.failed = !((text_char_i == rdtv_pkg::CH_DOT) || is_z || is_sign);
        if (is_sign) begin
          data_d.pos   = rdtv_pkg::ZPOS_FIRST;
          data_d.field = 7'd0;
        end
      end
      rdtv_pkg::PH_FRAC_1ST: data_d.failed = !is_dig;
      rdtv_pkg::PH_FRAC: begin
        data_d.failed = !(is_dig || is_z || is_sign);
        if (is_sign) begin
          data_d.pos   = rdtv_pkg::ZPOS_FIRST;
          data_d.field = 7'd0;
        end
      end
      rdtv_pkg::PH_ZONE: begin
        if (state_i.pos == rdtv_pkg::ZPOS_COLON) begin
          data_d.failed = (text_char_i != rdtv_pkg::CH_COLON);
          data_d.field  = 7'd0;
          data_d.pos    = 4'(state_i.pos + 4'd1);
        end else begin
          data_d.failed = !is_dig ||
                          ((state_i.pos == rdtv_pkg::ZPOS_HOUR) && (acc > rdtv_pkg::HOUR_MAX)) ||
                          ((state_i.pos == rdtv_pkg::ZPOS_MIN)  && (acc > rdtv_pkg::MIN_MAX));
          data_d.field  = acc;
          data_d.pos    = (state_i.pos == rdtv_pkg::ZPOS_MIN) ? 4'd0
                                                              : 4'(state_i.pos + 4'd1);
        end
      end
      rdtv_pkg::PH_END: data_d.failed = 1'b1;
      default: data_d.failed = 1'b1;
    endcase
  end

  // A failed string holds its state to the end
  always_comb begin
    if (state_i.failed) begin
      state_o = state_i;
    end else begin
      state_o       = data_d;
      state_o.phase = phase_d;
    end
  end

endmodule

`default_nettype wire

### rtl/rfc3339_date_time_validator.sv
// Date / time / date-time syntax checker, one character per input word.
// Input channel: in_valid_i / in_ready_o with text_char_i, is_last_i and
// no_char_i. A word with no_char_i high carries no character. The word with
// is_last_i high closes the string and yields one output word on
// out_valid_o / out_ready_i: is_valid_o is high when the whole string
// matches the format in force. Non-last words give no output.
// Format: cfg_we_i writes cfg_wdata_i (0 date, 1 time, 2 or 3 date-time)
// and restarts the parser; write only while the block is idle.
// Result: registered; it appears in the cycle after the last word is taken.
// Throughput: one word per cycle but for a stalled last word; each character
// passes one step of the parser between the state and result registers.
// Stall: while an unread result sits in the output register, non-last words
// are still taken; a last word waits until the register frees, which may be
// in the same cycle as out_ready_i takes the old result.
// Reset: format becomes date-time, the parser waits at the start of a
// string and the output register is empty.
`default_nettype none

module rfc3339_date_time_validator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_char_i,
  input  logic       is_last_i,
  input  logic       no_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_valid_o
);

  logic [1:0]       format_kind_q;
  rdtv_pkg::state_t state_q;
  rdtv_pkg::state_t step_d;
  rdtv_pkg::state_t state_after;
  logic             out_valid_q;
  logic             is_valid_q;
  logic             in_fire;
  logic             result;

  // Per-character parser step
  rdtv_step u_step (
    .state_i       (state_q),
    .format_kind_i (format_kind_q),
    .text_char_i   (text_char_i),
    .state_o       (step_d)
  );

  assign state_after = no_char_i ? state_q : step_d;
  assign result      = !state_after.failed && (state_after.phase == rdtv_pkg::PH_END);

  // Handshake: only a last word needs the output register free
  assign in_ready_o = !out_valid_q || out_ready_i || !is_last_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Format register and parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_kind_q <= rdtv_pkg::FMT_RESET;
      state_q       <= rdtv_pkg::start_state(rdtv_pkg::FMT_RESET);
    end else if (cfg_we_i) begin
      format_kind_q <= cfg_wdata_i;
      state_q       <= rdtv_pkg::start_state(cfg_wdata_i);
    end else if (in_fire) begin
      state_q <= is_last_i ? rdtv_pkg::start_state(format_kind_q) : state_after;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && is_last_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && is_last_i) begin
      is_valid_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_valid_o  = is_valid_q;

endmodule

`default_nettype wire

### rtl/rdtv_checker.sv
`default_nettype none

module rdtv_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_we_i,
  input logic [1:0] cfg_wdata_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] text_char_i,
  input logic       is_last_i,
  input logic       no_char_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       is_valid_o
);

  logic in_last_fire;

  assign in_last_fire = in_valid_i && in_ready_o && is_last_i;

  // A waiting result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(is_valid_o))
    else $error("output word dropped or changed while stalled");

  // A result only ever follows a last word
  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_last_fire))
    else $error("output word without a closing input word");

  // Every last word taken gives a result in the next cycle
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_fire |=> out_valid_o)
    else $error("closing input word gave no output word");

  // An empty string right after another string is invalid
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_last_fire && no_char_i && $past(in_last_fire) && !$past(cfg_we_i) && !cfg_we_i
    |=> !is_valid_o)
    else $error("empty string reported valid");

  // Input is never held off while the output register is empty
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output register");

  logic unused_ok;
  assign unused_ok = ^{cfg_wdata_i, text_char_i};

endmodule

bind rfc3339_date_time_validator rdtv_checker u_checker (.*);

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rdtv_pkg::*;

  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int          HOLD_CYCLES     = 300;
  localparam int          N_PHASES        = 8;
  localparam int          CHARS_PER_PHASE = 90;
  localparam int          N_DIR           = 28;
  // Spare format code, behaves as full date-time
  localparam logic [1:0]  FMT_SPARE       = 2'd3;

  typedef enum logic [1:0] {WANT_CALC, WANT_NO, WANT_YES} want_e;
  typedef enum logic [1:0] {ROW_PLAIN, ROW_HOLES, ROW_CUT} row_kind_e;

  typedef struct {
    logic [1:0] fmt;
    row_kind_e  kind;
    string      txt;
    want_e      want;
  } dir_row_t;

  // Directed strings: plain rows close on the final character, hole rows put an
  // empty word before each character and close with an empty word, cut rows
  // are abandoned and followed by a format rewrite
  dir_row_t dir_tab [N_DIR] = '{
    '{FMT_DATE_TIME, ROW_PLAIN, "1985-04-12T23:20:50.52Z", WANT_YES},
    '{FMT_DATE_TIME, ROW_HOLES, "", WANT_NO},
    '{FMT_DATE_TIME, ROW_PLAIN, "1996-12-19T16:39:57-08:00", WANT_YES},
    '{FMT_DATE_TIME, ROW_PLAIN, "1990-12-31t23:59:60z", WANT_YES},
    '{FMT_DATE_TIME, ROW_HOLES, "0000-01-01T00:00:00+00:00", WANT_YES},
    '{FMT_DATE_TIME, ROW_PLAIN, "9999-12-31T23:59:60.999999999-23:59", WANT_YES},
    '{FMT_DATE_TIME, ROW_PLAIN, "2020-02-29T12:00:00ZZ", WANT_NO},
    '{FMT_DATE_TIME, ROW_PLAIN, "2020-02-29 12:00:00Z", WANT_NO},
    '{FMT_DATE, ROW_PLAIN, "2000-02-29", WANT_YES},
    '{FMT_DATE, ROW_PLAIN, "1900-02-29", WANT_NO},
    '{FMT_DATE, ROW_PLAIN, "2024-02-29", WANT_CALC},
    '{FMT_DATE, ROW_PLAIN, "2023-02-29", WANT_CALC},
    '{FMT_DATE, ROW_PLAIN, "2023-13-01", WANT_NO},
    '{FMT_DATE, ROW_PLAIN, "2023-04-31", WANT_CALC},
    '{FMT_DATE, ROW_PLAIN, "2023-00-00", WANT_NO},
    '{FMT_DATE, ROW_PLAIN, "2023-04-300", WANT_NO},
    '{FMT_DATE, ROW_CUT, "2023-0", WANT_CALC},
    '{FMT_DATE, ROW_PLAIN, "2023-04-3", WANT_NO},
    '{FMT_TIME, ROW_PLAIN, "23:59:60.5+23:59", WANT_CALC},
    '{FMT_TIME, ROW_PLAIN, "24:00:00Z", WANT_NO},
    '{FMT_TIME, ROW_PLAIN, "00:60:61Z", WANT_CALC},
    '{FMT_TIME, ROW_PLAIN, "12:00:00.Z", WANT_CALC},
    '{FMT_TIME, ROW_PLAIN, "12:00:00-24:60", WANT_CALC},
    '{FMT_TIME, ROW_PLAIN, "12:00:00", WANT_NO},
    '{FMT_TIME, ROW_CUT, "12:00:0", WANT_CALC},
    '{FMT_SPARE, ROW_PLAIN, "2100-02-28T00:00:00z", WANT_CALC},
    '{FMT_SPARE, ROW_PLAIN, "12:00:00Z", WANT_NO},
    '{FMT_SPARE, ROW_HOLES, "2400-02-29T01:02:03.0+01:00", WANT_CALC}
  };

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [1:0] cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] text_char;
  logic       is_last;
  logic       no_char;
  logic       out_valid;
  logic       out_ready;
  logic       is_valid;

  // Checker model state
  logic [1:0]  fmt_reg;
  phase_e      parse_step;
  logic [3:0]  parse_pos;
  logic [13:0] yr_acc;
  logic [6:0]  mon_acc;
  logic [6:0]  day_acc;
  logic [6:0]  fld_acc;
  bit          parse_bad;

  bit          verdict_q [$];
  logic [7:0]  word_q [$];

  bit calm;
  bit hold_req;
  int stall_left;
  int fail_cnt;
  int cycle_cnt;
  int chars_sent;
  int strings_sent;
  int results_seen;
  int writes_done;
  bit want_bit;

  rfc3339_date_time_validator u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .text_char_i (text_char),
    .is_last_i   (is_last),
    .no_char_i   (no_char),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .is_valid_o  (is_valid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Checker model of the parser
  // ---------------------------------------------------------------------------

  function automatic void parse_restart();
    parse_step = (fmt_reg == FMT_TIME) ? PH_TIME : PH_DATE;
    parse_pos  = '0;
    yr_acc     = '0;
    mon_acc    = '0;
    day_acc    = '0;
    fld_acc    = '0;
    parse_bad  = 1'b0;
  endfunction

  function automatic bit is_num_char(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  // Gregorian month length; zero for a month out of range
  function automatic int days_in(int y, int m);
    int mdays [13] = '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    bit leap_yr;
    leap_yr = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    if (m < 1 || m > 12) return 0;
    if (m == 2 && leap_yr) return 29;
    return mdays[m];
  endfunction

  function automatic void parse_date_char(logic [7:0] c);
    int d;
    d = int'(c) - int'(CH_ZERO);
    if (parse_pos == DPOS_DASH1 || parse_pos == DPOS_DASH2) begin
      if (c != CH_DASH) begin
        parse_bad = 1'b1;
        return;
      end
    end else begin
      if (!is_num_char(c)) begin
        parse_bad = 1'b1;
        return;
      end
      if (parse_pos < DPOS_DASH1) yr_acc = 14'(yr_acc * 10 + d);
      else if (parse_pos < DPOS_DASH2) mon_acc = 7'(mon_acc * 10 + d);
      else day_acc = 7'(day_acc * 10 + d);
    end
    if (parse_pos == DPOS_LAST) begin
      if (mon_acc < 1 || mon_acc > MONTH_MAX || day_acc < 1 ||
          day_acc > days_in(int'(yr_acc), int'(mon_acc))) begin
        parse_bad = 1'b1;
        return;
      end
      parse_step = (fmt_reg == FMT_DATE) ? PH_END : PH_SEP;
      parse_pos  = '0;
      return;
    end
    parse_pos++;
  endfunction

  function automatic void parse_time_char(logic [7:0] c);
    if (parse_pos == TPOS_COLON1 || parse_pos == TPOS_COLON2) begin
      if (c != CH_COLON) begin
        parse_bad = 1'b1;
        return;
      end
      fld_acc = '0;
      parse_pos++;
      return;
    end
    if (!is_num_char(c)) begin
      parse_bad = 1'b1;
      return;
    end
    fld_acc = 7'(fld_acc * 10 + (c - CH_ZERO));
    if ((parse_pos == TPOS_HOUR && fld_acc > HOUR_MAX) ||
        (parse_pos == TPOS_MIN && fld_acc > MIN_MAX) ||
        (parse_pos == TPOS_SEC && fld_acc > SEC_MAX)) begin
      parse_bad = 1'b1;
      return;
    end
    if (parse_pos == TPOS_SEC) begin
      parse_step = PH_AFTER_SEC;
      parse_pos  = '0;
      fld_acc    = '0;
      return;
    end
    parse_pos++;
  endfunction

  function automatic void parse_zone_char(logic [7:0] c);
    if (parse_pos == ZPOS_COLON) begin
      if (c != CH_COLON) begin
        parse_bad = 1'b1;
        return;
      end
      fld_acc = '0;
      parse_pos++;
      return;
    end
    if (!is_num_char(c)) begin
      parse_bad = 1'b1;
      return;
    end
    fld_acc = 7'(fld_acc * 10 + (c - CH_ZERO));
    if ((parse_pos == ZPOS_HOUR && fld_acc > HOUR_MAX) ||
        (parse_pos == ZPOS_MIN && fld_acc > MIN_MAX)) begin
      parse_bad = 1'b1;
      return;
    end
    if (parse_pos == ZPOS_MIN) begin
      parse_step = PH_END;
      parse_pos  = '0;
      return;
    end
    parse_pos++;
  endfunction

  // Z closes the time, a sign opens the offset
  function automatic bit zone_opens(logic [7:0] c);
    if (c == CH_UP_Z || c == CH_LO_Z) begin
      parse_step = PH_END;
      return 1'b1;
    end
    if (c == CH_PLUS || c == CH_DASH) begin
      parse_step = PH_ZONE;
      parse_pos  = ZPOS_FIRST;
      fld_acc    = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    if (parse_bad) return;
    case (parse_step)
      PH_DATE: parse_date_char(c);
      PH_SEP: begin
        if (c == CH_UP_T || c == CH_LO_T) begin
          parse_step = PH_TIME;
          parse_pos  = '0;
          fld_acc    = '0;
        end else begin
          parse_bad = 1'b1;
        end
      end
      PH_TIME: parse_time_char(c);
      PH_AFTER_SEC: begin
        if (c == CH_DOT) parse_step = PH_FRAC_1ST;
        else if (!zone_opens(c)) parse_bad = 1'b1;
      end
      PH_FRAC_1ST: begin
        if (is_num_char(c)) parse_step = PH_FRAC;
        else parse_bad = 1'b1;
      end
      PH_FRAC: begin
        if (!is_num_char(c) && !zone_opens(c)) parse_bad = 1'b1;
      end
      PH_ZONE: parse_zone_char(c);
      default: parse_bad = 1'b1;
    endcase
  endfunction

  // One accepted word; returns 1 when it closes a string, with its verdict
  function automatic bit judge_word(logic [7:0] c, bit last, bit none, output bit ok);
    ok = 1'b0;
    if (!none) parse_char(c);
    if (!last) return 1'b0;
    ok = !parse_bad && parse_step == PH_END;
    parse_restart();
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Random string builders, all working on word_q
  // ---------------------------------------------------------------------------

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly lo..hi, otherwise below lo or above hi (up to 99)
  function automatic int pick_field(int lo, int hi, int pct);
    if ($urandom_range(0, 99) < pct) return $urandom_range(lo, hi);
    if (lo > 0 && $urandom_range(0, 1) == 1) return $urandom_range(0, lo - 1);
    return $urandom_range(hi + 1, 99);
  endfunction

  function automatic void push_digits(int v, int n);
    int div;
    div = 1;
    repeat (n - 1) div *= 10;
    repeat (n) begin
      word_q.push_back(8'(CH_ZERO + (v / div) % 10));
      div /= 10;
    end
  endfunction

  function automatic logic [7:0] near_miss();
    case ($urandom_range(0, 9))
      0: return CH_DASH;
      1: return CH_COLON;
      2: return CH_PLUS;
      3: return CH_DOT;
      4: return CH_UP_T;
      5: return CH_LO_Z;
      6: return CH_ZERO - 8'd1;
      7: return CH_NINE + 8'd1;
      8: return CH_ZERO;
      default: return CH_NINE;
    endcase
  endfunction

  function automatic void push_date();
    int y;
    case ($urandom_range(0, 5))
      0: y = 0;
      1: y = 100 * $urandom_range(0, 99);
      2: y = 4 * $urandom_range(0, 2499);
      default: y = $urandom_range(0, 9999);
    endcase
    push_digits(y, 4);
    word_q.push_back(CH_DASH);
    push_digits(pick_field(1, 12, 90), 2);
    word_q.push_back(CH_DASH);
    push_digits(($urandom_range(0, 2) == 0) ? $urandom_range(29, 31) : pick_field(1, 28, 90), 2);
  endfunction

  function automatic void push_time();
    int r;
    push_digits(pick_field(0, 23, 90), 2);
    word_q.push_back(CH_COLON);
    push_digits(pick_field(0, 59, 92), 2);
    word_q.push_back(CH_COLON);
    push_digits(pick_field(0, 60, 92), 2);
    if ($urandom_range(0, 99) < 40) begin
      word_q.push_back(CH_DOT);
      repeat ($urandom_range(1, 4)) word_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    end
    r = $urandom_range(0, 99);
    if (r < 30) word_q.push_back(CH_UP_Z);
    else if (r < 45) word_q.push_back(CH_LO_Z);
    else begin
      word_q.push_back((r < 72) ? CH_PLUS : CH_DASH);
      push_digits(pick_field(0, 23, 90), 2);
      word_q.push_back(CH_COLON);
      push_digits(pick_field(0, 59, 90), 2);
    end
  endfunction

  // Replace, drop, insert, truncate or swap in a near-miss character
  function automatic void mangle();
    int n;
    int p;
    n = word_q.size();
    p = (n == 0) ? 0 : $urandom_range(0, n - 1);
    case ((n == 0) ? 2 : $urandom_range(0, 4))
      0: word_q[p] = 8'($urandom_range(0, 255));
      1: word_q.delete(p);
      2: word_q.insert($urandom_range(0, n), 8'($urandom_range(0, 255)));
      3: repeat (n - p) void'(word_q.pop_back());
      default: word_q[p] = near_miss();
    endcase
  endfunction

  function automatic void make_text(logic [1:0] fmt);
    int r;
    logic [1:0] shape;
    word_q.delete();
    r = $urandom_range(0, 99);
    if (r < 3) begin
      repeat ($urandom_range(0, 24)) word_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    shape = (r < 10) ? 2'($urandom_range(0, 2)) : fmt;
    if (shape != FMT_TIME) push_date();
    if (shape == FMT_DATE_TIME || shape == FMT_SPARE)
      word_q.push_back(($urandom_range(0, 3) == 0) ? CH_LO_T : CH_UP_T);
    if (shape != FMT_DATE) push_time();
    if ($urandom_range(0, 99) < 22) mangle();
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver
  // ---------------------------------------------------------------------------

  task automatic put_word(input logic [7:0] c, input bit last, input bit none,
                          input want_e want);
    int gap;
    bit ok;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    text_char <= c;
    is_last   <= last;
    no_char   <= none;
    do @(posedge clk); while (!in_ready);
    if (!none) chars_sent++;
    if (judge_word(c, last, none, ok)) begin
      verdict_q.push_back((want == WANT_CALC) ? ok : (want == WANT_YES));
      strings_sent++;
    end
  endtask

  // Send word_q as one string, optionally with empty words mixed in
  task automatic send_text(input bit closed, input int hole_pct, input bit tail_none,
                           input want_e want);
    int n;
    n = word_q.size();
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < hole_pct)
        put_word(8'($urandom_range(0, 255)), 1'b0, 1'b1, want);
      put_word(word_q[k], closed && !tail_none && (k == n - 1), 1'b0, want);
    end
    if (closed && (tail_none || n == 0))
      put_word(8'($urandom_range(0, 255)), 1'b1, 1'b1, want);
  endtask

  // Stop offering and wait for every outstanding verdict
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_format(input logic [1:0] f);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= f;
    @(negedge clk);
    cfg_we    <= 1'b0;
    fmt_reg = f;
    parse_restart();
    writes_done++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, plus one long hold on request
  // ---------------------------------------------------------------------------

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          stall_left = gap - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // Compare each taken result word with the oldest verdict
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("unexpected result word: is_valid=%0b", is_valid);
        fail_cnt++;
      end else begin
        want_bit = verdict_q.pop_front();
        results_seen++;
        if (is_valid !== want_bit) begin
          $error("is_valid mismatch: expected %0b, actual %0b", want_bit, is_valid);
          fail_cnt++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("rfc3339_date_time_validator regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin
    string      row_txt;
    logic [1:0] fmt_sel;
    int         budget;
    int         cut_len;

    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = FMT_RESET;
    in_valid   = 1'b0;
    text_char  = '0;
    is_last    = 1'b0;
    no_char    = 1'b0;
    out_ready  = 1'b0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    stall_left = 0;
    fmt_reg    = FMT_RESET;
    parse_restart();

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed strings
    for (int i = 0; i < N_DIR; i++) begin
      if (dir_tab[i].fmt != fmt_reg) write_format(dir_tab[i].fmt);
      row_txt = dir_tab[i].txt;
      word_q.delete();
      for (int k = 0; k < row_txt.len(); k++) word_q.push_back(row_txt[k]);
      send_text(dir_tab[i].kind != ROW_CUT, (dir_tab[i].kind == ROW_HOLES) ? 100 : 0,
                dir_tab[i].kind == ROW_HOLES, dir_tab[i].want);
      // format rewrite part way through a string restarts the parser
      if (dir_tab[i].kind == ROW_CUT) write_format(dir_tab[i].fmt);
    end

    // Random phases, each under its own format and idling style
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: fmt_sel = FMT_DATE;
        1: fmt_sel = FMT_TIME;
        2: fmt_sel = FMT_DATE_TIME;
        3: fmt_sel = FMT_SPARE;
        default: fmt_sel = 2'($urandom_range(0, 3));
      endcase
      // sometimes leave a half-sent string for the format write to discard
      if ($urandom_range(0, 1) == 1) begin
        make_text(fmt_reg);
        cut_len = $urandom_range(0, word_q.size());
        while (word_q.size() > cut_len) void'(word_q.pop_back());
        send_text(1'b0, 5, 1'b0, WANT_CALC);
      end
      calm = (ph == 1 || ph == 5);
      write_format(fmt_sel);
      if (ph == 2) hold_req = 1'b1;
      budget = chars_sent + CHARS_PER_PHASE;
      while (chars_sent < budget) begin
        make_text(fmt_reg);
        send_text(1'b1, 5, $urandom_range(0, 4) == 0, WANT_CALC);
      end
    end

    settle();
    repeat (20) @(posedge clk);

    $display("covered %0d strings of %0d characters under %0d format writes, all four codes",
             strings_sent, chars_sent, writes_done);
    $display("%0d results checked, %0d mismatches", results_seen, fail_cnt);
    if (fail_cnt == 0 && verdict_q.size() == 0) begin
      $display("rfc3339_date_time_validator regression: pass");
    end else begin
      $display("rfc3339_date_time_validator regression: fail");
    end
    $finish;
  end

endmodule

### files.f
rtl/rdtv_pkg.sv
rtl/rdtv_step.sv
rtl/rfc3339_date_time_validator.sv
rtl/rdtv_checker.sv
verif/tb_top.sv
